FILE: sv/qfavm_pkg.sv
// Shared constants, types and tables for the quad face metrics pipeline.
package qfavm_pkg;

  localparam int COORD_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SUM_W        = COORD_W + 2;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1 - (FRAC_W + 1);
  localparam int SQ_W         = 2 * COORD_W;
  localparam int ROOT_W       = 32;
  localparam int ANGLE_W      = 18;
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_W     = 36;
  localparam int Z_W          = 32;
  localparam int ZR_W         = Z_W + 1 - 14;
  localparam int HALF_PI      = 102944;
  localparam int UP_W         = 5;

  // Stage where each result appears, counted in register stages after accept.
  localparam int LAT       = 39;
  localparam int SIDE_DLY  = 34;
  localparam int RAD_DLY   = 3;
  localparam int ANG_DLY   = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t n_x;
    coord_t n_y;
    coord_t n_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    logic   sat;
  } side_t;

  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic y_pos;
  } aflag_t;

  // atan(2^-i) scaled by 2^30
  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = Z_W'(843314857);
      1:       v = Z_W'(497837829);
      2:       v = Z_W'(263043837);
      3:       v = Z_W'(133525159);
      4:       v = Z_W'(67021687);
      5:       v = Z_W'(33543516);
      6:       v = Z_W'(16775851);
      7:       v = Z_W'(8388437);
      8:       v = Z_W'(4194283);
      9:       v = Z_W'(2097149);
      default: v = (i <= 30) ? Z_W'(64'd1 << (30 - i)) : '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/quad_face_area_vector_metrics.sv
// Quad face metrics: area vector, centroid, radius, angle and area, fully pipelined.
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+------------------------
//  item in  | corner0_x .. corner3_z              | start high, busy low
//  item out | normal_*, center_*, radius, angle,  | done high for one cycle
//           | face_area, saturated                |
//
// One item enters per cycle.
// Latency is set by the face area path: cross products, squares, and a
// 32-stage square root unit with one root bit per stage.
// rst (synchronous) clears only the valid chain; busy stays low.
// The receiver cannot stall, so data registers advance every cycle.
module quad_face_area_vector_metrics
  import qfavm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] corner0_x,
  input  logic signed [COORD_W-1:0] corner0_y,
  input  logic signed [COORD_W-1:0] corner0_z,
  input  logic signed [COORD_W-1:0] corner1_x,
  input  logic signed [COORD_W-1:0] corner1_y,
  input  logic signed [COORD_W-1:0] corner1_z,
  input  logic signed [COORD_W-1:0] corner2_x,
  input  logic signed [COORD_W-1:0] corner2_y,
  input  logic signed [COORD_W-1:0] corner2_z,
  input  logic signed [COORD_W-1:0] corner3_x,
  input  logic signed [COORD_W-1:0] corner3_y,
  input  logic signed [COORD_W-1:0] corner3_z,
  output logic                      done,
  output logic signed [COORD_W-1:0] normal_x,
  output logic signed [COORD_W-1:0] normal_y,
  output logic signed [COORD_W-1:0] normal_z,
  output logic signed [COORD_W-1:0] center_x,
  output logic signed [COORD_W-1:0] center_y,
  output logic signed [COORD_W-1:0] center_z,
  output logic [ROOT_W-1:0]         radius,
  output logic signed [ANGLE_W-1:0] angle,
  output logic [ROOT_W-1:0]         face_area,
  output logic                      saturated
);

  localparam logic signed [ZR_W-1:0] ANG_MAX = ZR_W'(HALF_PI);
  localparam logic signed [ZR_W-1:0] ANG_MIN = -ZR_W'(HALF_PI);

  logic accept;
  logic [LAT-1:0] vpipe;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  assign done = vpipe[LAT-1];

  // ---- stage 1: diagonals and centroid
  coord_t corner [4][3];
  assign corner[0][0] = corner0_x;
  assign corner[0][1] = corner0_y;
  assign corner[0][2] = corner0_z;
  assign corner[1][0] = corner1_x;
  assign corner[1][1] = corner1_y;
  assign corner[1][2] = corner1_z;
  assign corner[2][0] = corner2_x;
  assign corner[2][1] = corner2_y;
  assign corner[2][2] = corner2_z;
  assign corner[3][0] = corner3_x;
  assign corner[3][1] = corner3_y;
  assign corner[3][2] = corner3_z;

  logic signed [DIFF_W-1:0] d1 [3];
  logic signed [DIFF_W-1:0] e1 [3];
  coord_t cen1 [3];
  logic signed [SUM_W-1:0] sum1 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum1[a] = SUM_W'(corner[0][a]) + SUM_W'(corner[1][a]) + SUM_W'(corner[2][a])
              + SUM_W'(corner[3][a]) + SUM_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      d1[a]   <= DIFF_W'(corner[2][a]) - DIFF_W'(corner[0][a]);
      e1[a]   <= DIFF_W'(corner[3][a]) - DIFF_W'(corner[1][a]);
      cen1[a] <= sum1[a][SUM_W-1:2];
    end
  end

  // ---- stage 2: products, centroid squares, angle prep
  logic signed [PROD_W-1:0] prod2 [6];
  logic signed [SQ_W-1:0]   sqx2, sqy2;
  logic signed [DIFF_W-1:0] ax2, ay2;
  aflag_t flags2;
  coord_t cen2 [3];

  always_ff @(posedge clk) begin
    prod2[0] <= d1[1] * e1[2];
    prod2[1] <= d1[2] * e1[1];
    prod2[2] <= d1[2] * e1[0];
    prod2[3] <= d1[0] * e1[2];
    prod2[4] <= d1[0] * e1[1];
    prod2[5] <= d1[1] * e1[0];
    sqx2 <= cen1[0] * cen1[0];
    sqy2 <= cen1[1] * cen1[1];
    flags2.y_zero <= (cen1[1] == '0);
    flags2.x_zero <= (cen1[0] == '0);
    flags2.y_pos  <= ~cen1[1][COORD_W-1];
    // fold the left half plane onto the right
    if (cen1[0][COORD_W-1]) begin
      ax2 <= -DIFF_W'(cen1[0]);
      ay2 <= -DIFF_W'(cen1[1]);
    end else begin
      ax2 <= DIFF_W'(cen1[0]);
      ay2 <= DIFF_W'(cen1[1]);
    end
    cen2 <= cen1;
  end

  // ---- stage 3: cross terms rounded, radius radicand, normalize count
  logic signed [PROD_W:0]    diff3 [3];
  logic signed [CROSS_W-1:0] cross3 [3];
  logic [SQ_W-1:0]           rad3;
  logic [DIFF_W-1:0]         m3;
  logic [DIFF_W-1:0]         aby3;
  logic [UP_W-1:0]           up_c, up3;
  logic signed [DIFF_W-1:0]  ax3, ay3;
  aflag_t flags3;
  coord_t cen3 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff3[k] = (PROD_W+1)'(prod2[2*k]) - (PROD_W+1)'(prod2[2*k+1])
               + (PROD_W+1)'(64'd1 << FRAC_W);
    end
    aby3 = ay2[DIFF_W-1] ? DIFF_W'(-ay2) : DIFF_W'(ay2);
    m3   = ($unsigned(ax2) > aby3) ? $unsigned(ax2) : aby3;
    up_c = '0;
    for (int b = 0; b < 30; b++) begin
      if (m3[b]) up_c = UP_W'(30 - b);
    end
    if (m3[30] | m3[31] | m3[32]) up_c = '0;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      cross3[k] <= diff3[k][PROD_W:FRAC_W+1];
    end
    rad3   <= $unsigned(sqx2) + $unsigned(sqy2);
    up3    <= up_c;
    ax3    <= ax2;
    ay3    <= ay2;
    flags3 <= flags2;
    cen3   <= cen2;
  end

  // ---- stage 4: saturate area vector, normalize CORDIC inputs
  side_t  side_c, side4;
  coord_t n_c [3];
  logic   sat_c;
  logic signed [CORDIC_W-1:0] cx4, cy4;
  aflag_t flags4;

  always_comb begin
    sat_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ((&cross3[k][CROSS_W-1:COORD_W-1]) | ~(|cross3[k][CROSS_W-1:COORD_W-1])) begin
        n_c[k] = cross3[k][COORD_W-1:0];
      end else begin
        sat_c  = 1'b1;
        n_c[k] = cross3[k][CROSS_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                      : {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
    side_c.n_x = n_c[0];
    side_c.n_y = n_c[1];
    side_c.n_z = n_c[2];
    side_c.c_x = cen3[0];
    side_c.c_y = cen3[1];
    side_c.c_z = cen3[2];
    side_c.sat = sat_c;
  end

  always_ff @(posedge clk) begin
    side4  <= side_c;
    cx4    <= CORDIC_W'(ax3) <<< up3;
    cy4    <= CORDIC_W'(ay3) <<< up3;
    flags4 <= flags3;
  end

  // ---- CORDIC vectoring, one rotation per stage
  logic signed [CORDIC_W-1:0] cx_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy_q [CORDIC_STEPS];
  logic signed [Z_W-1:0]      z_q  [CORDIC_STEPS];
  aflag_t                     fl_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CORDIC_W-1:0] x_in, y_in, xs, ys;
    logic signed [Z_W-1:0]      z_in;
    aflag_t                     f_in;

    if (i == 0) begin : g_first
      assign x_in = cx4;
      assign y_in = cy4;
      assign z_in = '0;
      assign f_in = flags4;
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = z_q[i-1];
      assign f_in = fl_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk) begin
      if (!y_in[CORDIC_W-1]) begin
        cx_q[i] <= x_in + ys;
        cy_q[i] <= y_in - xs;
        z_q[i]  <= z_in + atan_entry(i);
      end else begin
        cx_q[i] <= x_in - ys;
        cy_q[i] <= y_in + xs;
        z_q[i]  <= z_in - atan_entry(i);
      end
      fl_q[i] <= f_in;
    end
  end

  // ---- round, clamp and special-case the angle
  logic signed [Z_W:0]        zr_c;
  logic signed [ZR_W-1:0]     q_c, qc_c;
  logic signed [ANGLE_W-1:0]  ang_c, ang36;
  aflag_t                     fl_end;

  assign fl_end = fl_q[CORDIC_STEPS-1];

  always_comb begin
    zr_c = (Z_W+1)'(z_q[CORDIC_STEPS-1]) + (Z_W+1)'(1 << 13);
    q_c  = zr_c[Z_W:14];
    if (q_c > ANG_MAX) begin
      qc_c = ANG_MAX;
    end else if (q_c < ANG_MIN) begin
      qc_c = ANG_MIN;
    end else begin
      qc_c = q_c;
    end
    if (fl_end.y_zero) begin
      ang_c = '0;
    end else if (fl_end.x_zero) begin
      ang_c = fl_end.y_pos ? ANGLE_W'(ANG_MAX) : ANGLE_W'(ANG_MIN);
    end else begin
      ang_c = qc_c[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    ang36 <= ang_c;
  end

  // ---- area magnitude radicand
  logic signed [SQ_W-1:0] sqn5 [3];
  logic [SQ_W-1:0]        area_rad6;

  always_ff @(posedge clk) begin
    sqn5[0]   <= side4.n_x * side4.n_x;
    sqn5[1]   <= side4.n_y * side4.n_y;
    sqn5[2]   <= side4.n_z * side4.n_z;
    area_rad6 <= $unsigned(sqn5[0]) + $unsigned(sqn5[1]) + $unsigned(sqn5[2]);
  end

  // ---- square roots
  logic [ROOT_W-1:0] radius_root, area_root;

  qfavm_isqrt u_radius_sqrt (
    .clk      (clk),
    .radicand (rad3),
    .root     (radius_root)
  );

  qfavm_isqrt u_area_sqrt (
    .clk      (clk),
    .radicand (area_rad6),
    .root     (area_root)
  );

  // ---- align side results with the area root
  side_t                     side_d [SIDE_DLY];
  logic [ROOT_W-1:0]         rad_d  [RAD_DLY];
  logic signed [ANGLE_W-1:0] ang_d  [ANG_DLY];

  always_ff @(posedge clk) begin
    side_d[0] <= side4;
    for (int k = 1; k < SIDE_DLY; k++) side_d[k] <= side_d[k-1];
    rad_d[0] <= radius_root;
    for (int k = 1; k < RAD_DLY; k++) rad_d[k] <= rad_d[k-1];
    ang_d[0] <= ang36;
    for (int k = 1; k < ANG_DLY; k++) ang_d[k] <= ang_d[k-1];
  end

  // ---- output register
  always_ff @(posedge clk) begin
    normal_x  <= side_d[SIDE_DLY-1].n_x;
    normal_y  <= side_d[SIDE_DLY-1].n_y;
    normal_z  <= side_d[SIDE_DLY-1].n_z;
    center_x  <= side_d[SIDE_DLY-1].c_x;
    center_y  <= side_d[SIDE_DLY-1].c_y;
    center_z  <= side_d[SIDE_DLY-1].c_z;
    saturated <= side_d[SIDE_DLY-1].sat;
    radius    <= rad_d[RAD_DLY-1];
    angle     <= ang_d[ANG_DLY-1];
    face_area <= area_root;
  end

endmodule

FILE: sv/qfavm_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
module qfavm_isqrt
  import qfavm_pkg::*;
(
  input  logic              clk,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   rad_q  [ROOT_W-1];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   rad_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    // bring down the next two radicand bits, try root bit one
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rem_sh >= trial) begin
        rem_q[j]  <= rem_sh - trial;
        root_q[j] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[j]  <= rem_sh;
        root_q[j] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    if (j < ROOT_W - 1) begin : g_rad
      always_ff @(posedge clk) begin
        rad_q[j] <= {rad_in[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule
